[src/prr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the polyphase rational resampler.
package prr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W = 32;
   localparam int OUT_W = 32;
   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int INDEX_W = 8;

   localparam int INTERP_W = 5;
   localparam int DECIM_W = 7;
   localparam int LENGTH_W = 9;
   localparam int SHIFT_W = 6;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int RESULT_LIMIT = 16;
   localparam int RESULT_CNT_W = $clog2(RESULT_LIMIT);

   localparam logic [CSR_IDX_W-1:0] REG_INTERP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT = 2'd3;

   localparam logic [INTERP_W-1:0] INTERP_RESET = 5'd1;
   localparam logic [DECIM_W-1:0] DECIM_RESET = 7'd52;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 9'd48;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd31;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_COEF = 1'b1;

   typedef struct packed {
      logic operation;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic [INDEX_W-1:0] coef_index;
      logic signed [COEF_W-1:0] coef_value;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] sample_out;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic issue;
      logic use_term;
      logic finish;
   } mac_ctrl_type;

   typedef struct packed {
      logic busy;
   } mac_stat_type;

endpackage

[src/polyphase_rational_resampler_unit.sv]
`timescale 1ns / 1ps
// Top level of the polyphase rational resampler.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-------------------------------------
//  req     | in        | req_valid/req_stall | operation, sample_in, coef_index,
//          |           |                     | coef_value
//  rsp     | out       | rsp_valid/rsp_stall | sample_out, last
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data (register write)
//
// A coefficient word is written to the coefficient memory as it is taken. For a sample word
// with T taps per phase (at least 1) that causes N outputs, one pass of the delay
// memory's single read port shifts the line, then one pass per output walks the taps
// through the shared multiplier. Reset restores the register defaults and sets the
// phase to 1; the delay line reads as zero above its written high-water mark, so no
// clearing pass is needed. A stalled result waits in the output register while the
// block goes idle and takes the next word; a following result holds until it is free.
module polyphase_rational_resampler_unit #(
   parameter int MAX_COEFFS = 256,
   parameter int MAX_INTERP = 16,
   parameter int MAX_DECIM = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  prr_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output prr_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [prr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [prr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import prr_pkg::*;

   // Widths of the clamped factors, memory addresses and tap arithmetic.
   localparam int IW = $clog2(MAX_INTERP + 1);
   localparam int DW = $clog2(MAX_DECIM + 1);
   localparam int LW = $clog2(MAX_COEFFS + 1);
   localparam int AW = $clog2(MAX_COEFFS);
   localparam int HW = AW + 1;
   localparam int PW = $clog2(MAX_INTERP + MAX_DECIM);
   localparam int SW = $clog2(MAX_COEFFS + 2 * MAX_INTERP + 1);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SHIFT  = 7'b0000010,
      S_CHECK  = 7'b0000100,
      S_MAC    = 7'b0001000,
      S_DRAIN  = 7'b0010000,
      S_FINISH = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   // Configuration registers.
   logic [INTERP_W-1:0] interp_ff, interp_in;
   logic [DECIM_W-1:0] decim_ff, decim_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;

   // Sequencer state.
   state_type state_ff, state_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic [AW-1:0] k_ff, k_in;
   logic [SW-1:0] m_ff, m_in;
   logic [RESULT_CNT_W-1:0] count_ff, count_in;
   logic [SAMPLE_W-1:0] carry_ff, carry_in;
   logic [HW-1:0] hwm_ff, hwm_in;
   logic wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic rd_zero_ff, rd_zero_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Derived values.
   logic [IW-1:0] p_c;
   logic [DW-1:0] q_c;
   logic [LW-1:0] len_c;
   logic [SW-1:0] p_s;
   logic [SW-1:0] len_s;
   logic [SW-1:0] ci;
   logic tap_here;
   logic tap_next;
   logic req_accept;
   logic out_free;
   logic last_c;

   // Memory ports.
   logic coef_we;
   logic [COEF_W-1:0] coef_rdata;
   logic [SAMPLE_W-1:0] dly_rdata;

   mac_ctrl_type mac_ctrl;
   mac_stat_type mac_stat;
   logic signed [OUT_W-1:0] mac_result;

   // Clamp the factors into their legal ranges.
   always_comb begin
      if (interp_ff == '0) begin
         p_c = IW'(1);
      end else if (32'(interp_ff) > MAX_INTERP) begin
         p_c = IW'(MAX_INTERP);
      end else begin
         p_c = IW'(interp_ff);
      end
      if (decim_ff == '0) begin
         q_c = DW'(1);
      end else if (32'(decim_ff) > MAX_DECIM) begin
         q_c = DW'(MAX_DECIM);
      end else begin
         q_c = DW'(decim_ff);
      end
      if (length_ff == '0) begin
         len_c = LW'(1);
      end else if (32'(length_ff) > MAX_COEFFS) begin
         len_c = LW'(MAX_COEFFS);
      end else begin
         len_c = LW'(length_ff);
      end
   end

   assign p_s = SW'(p_c);
   assign len_s = SW'(len_c);

   // m tracks k * interp; tap k exists while (k + 1) * interp fits in the length.
   assign tap_here = (m_ff + p_s) <= len_s;
   assign tap_next = (m_ff + p_s + p_s) <= len_s;
   // During an output pass the phase is below interp, so it fits in SW bits.
   assign ci = SW'(phase_ff) + m_ff;

   // An offered register write holds off the input so the two never share an edge.
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign req_accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_c = ((phase_ff + PW'(q_c)) >= PW'(p_c)) ||
                   (count_ff == RESULT_CNT_W'(RESULT_LIMIT - 1));

   // Configuration writes: ready only while the block is idle.
   assign csr_ready = (state_ff == S_IDLE);

   always_comb begin
      interp_in = interp_ff;
      decim_in = decim_ff;
      length_in = length_ff;
      shift_in = shift_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_INTERP: interp_in = csr_data[INTERP_W-1:0];
            REG_DECIM:  decim_in = csr_data[DECIM_W-1:0];
            REG_LENGTH: length_in = csr_data[LENGTH_W-1:0];
            REG_SHIFT:  shift_in = csr_data[SHIFT_W-1:0];
            default:    interp_in = interp_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      k_in = k_ff;
      m_in = m_ff;
      count_in = count_ff;
      carry_in = carry_ff;
      hwm_in = hwm_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      rd_zero_in = rd_zero_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      mac_ctrl = '0;
      coef_we = 1'b0;

      // Drop the held result once the far side takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Delay line shift write: store the carried word, carry the old entry onward.
      // Entries at or above the high-water mark were never written and read as zero.
      if (wr_pend_ff) begin
         carry_in = rd_zero_ff ? '0 : dly_rdata;
         if (HW'(wr_addr_ff) >= hwm_ff) begin
            hwm_in = HW'(wr_addr_ff) + HW'(1);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_data.operation == OP_COEF) begin
                  coef_we = 32'(req_data.coef_index) < MAX_COEFFS;
               end else begin
                  // Step the phase back by interp, saturating at zero.
                  phase_in = (phase_ff >= PW'(p_c)) ? (phase_ff - PW'(p_c)) : '0;
                  carry_in = req_data.sample_in;
                  k_in = '0;
                  m_in = '0;
                  count_in = '0;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            // Read entry k now, write it next cycle; slot 0 is always written.
            wr_pend_in = 1'b1;
            wr_addr_in = k_ff;
            rd_zero_in = HW'(k_ff) >= hwm_ff;
            if (tap_next) begin
               k_in = k_ff + AW'(1);
               m_in = m_ff + p_s;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // The last shift write lands here; start the first output if due.
            k_in = '0;
            m_in = '0;
            mac_ctrl.clear = 1'b1;
            state_in = (phase_ff < PW'(p_c)) ? S_MAC : S_IDLE;
         end
         S_MAC: begin
            mac_ctrl.issue = 1'b1;
            mac_ctrl.use_term = tap_here && (32'(ci) < MAX_COEFFS) &&
                                (HW'(k_ff) < hwm_ff);
            if (tap_next) begin
               k_in = k_ff + AW'(1);
               m_in = m_ff + p_s;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!mac_stat.busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            mac_ctrl.finish = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // Hold until the output register is free, then advance the phase.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.sample_out = mac_result;
               rsp_data_in.last = last_c;
               phase_in = phase_ff + PW'(q_c);
               count_in = count_ff + RESULT_CNT_W'(1);
               k_in = '0;
               m_in = '0;
               mac_ctrl.clear = 1'b1;
               state_in = last_c ? S_IDLE : S_MAC;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interp_ff <= INTERP_RESET;
         decim_ff <= DECIM_RESET;
         length_ff <= LENGTH_RESET;
         shift_ff <= SHIFT_RESET;
         state_ff <= S_IDLE;
         phase_ff <= PW'(1);
         hwm_ff <= '0;
         wr_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff <= '0;
         m_ff <= '0;
         count_ff <= '0;
      end else begin
         interp_ff <= interp_in;
         decim_ff <= decim_in;
         length_ff <= length_in;
         shift_ff <= shift_in;
         state_ff <= state_in;
         phase_ff <= phase_in;
         hwm_ff <= hwm_in;
         wr_pend_ff <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff <= k_in;
         m_ff <= m_in;
         count_ff <= count_in;
      end
      carry_ff <= carry_in;
      wr_addr_ff <= wr_addr_in;
      rd_zero_ff <= rd_zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   prr_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(MAX_COEFFS)
   ) u_delay_ram (
      .clock(clock),
      .wr_en(wr_pend_ff),
      .wr_addr(wr_addr_ff),
      .wr_data(carry_ff),
      .rd_en(1'b1),
      .rd_addr(k_ff),
      .rd_data(dly_rdata)
   );

   prr_ram #(
      .WIDTH(COEF_W),
      .DEPTH(MAX_COEFFS)
   ) u_coef_ram (
      .clock(clock),
      .wr_en(coef_we),
      .wr_addr(AW'(req_data.coef_index)),
      .wr_data(req_data.coef_value),
      .rd_en(1'b1),
      .rd_addr(ci[AW-1:0]),
      .rd_data(coef_rdata)
   );

   prr_mac #(
      .MAX_COEFFS(MAX_COEFFS)
   ) u_mac (
      .clock(clock),
      .reset(reset),
      .ctrl(mac_ctrl),
      .coef_data(coef_rdata),
      .smp_data(dly_rdata),
      .shift_amt(shift_ff),
      .stat(mac_stat),
      .result(mac_result)
   );

endmodule

[src/prr_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module prr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/prr_mac.sv]
`timescale 1ns / 1ps
// Multiply-accumulate pipeline with final arithmetic shift and saturation.
module prr_mac #(
   parameter int MAX_COEFFS = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  prr_pkg::mac_ctrl_type                 ctrl,
   input  logic signed [prr_pkg::COEF_W-1:0]     coef_data,
   input  logic signed [prr_pkg::SAMPLE_W-1:0]   smp_data,
   input  logic [prr_pkg::SHIFT_W-1:0]           shift_amt,
   output prr_pkg::mac_stat_type                 stat,
   output logic signed [prr_pkg::OUT_W-1:0]      result
);
   import prr_pkg::*;

   localparam int ACC_W = PROD_W + $clog2(MAX_COEFFS);
   localparam logic signed [ACC_W-1:0] OUT_MAX =
      {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

   logic s1_valid_ff, s1_valid_in;
   logic s1_use_ff, s1_use_in;
   logic s2_valid_ff, s2_valid_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] shifted_ff, shifted_in;

   always_comb begin
      s1_valid_in = ctrl.issue;
      s1_use_in = ctrl.use_term;
      s2_valid_in = s1_valid_ff;
      prod_in = prod_ff;
      if (s1_valid_ff) begin
         prod_in = s1_use_ff ? PROD_W'(coef_data * smp_data) : '0;
      end
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (s2_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      shifted_in = ctrl.finish ? (acc_ff >>> shift_amt) : shifted_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_use_ff <= s1_use_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      shifted_ff <= shifted_in;
   end

   always_comb begin
      if (shifted_ff > OUT_MAX) begin
         result = OUT_MAX[OUT_W-1:0];
      end else if (shifted_ff < OUT_MIN) begin
         result = OUT_MIN[OUT_W-1:0];
      end else begin
         result = shifted_ff[OUT_W-1:0];
      end
   end

   assign stat.busy = s1_valid_ff | s2_valid_ff;

endmodule
